>>> hdl/dopt_pkg.sv
// ============================================================================
// dopt_pkg
// Shared types and constants for the DHCP option parser with slot table.
// ============================================================================
`default_nettype none

package dopt_pkg;

  localparam int unsigned AreaLenW = 10;
  localparam int unsigned PosW = 10;

  localparam logic [AreaLenW-1:0] AreaLenReset = 10'd308;
  localparam logic [PosW-1:0] PosMax = 10'h3FF;
  localparam logic [7:0] PadCode = 8'h00;
  localparam logic [7:0] TermCode = 8'hFF;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_BYTE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_LEN  = 2'd1,
    PH_SKIP = 2'd2
  } phase_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic clear;
    logic byte_en;
    logic load_status;
    logic scan_start;
    logic scan_run;
    logic load_lookup;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/dopt_ram.sv
// ============================================================================
// dopt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module dopt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/dopt_datapath.sv
// ============================================================================
// dopt_datapath
// Option parse registers, slot table memories with valid bits, lookup scan
// pipeline and result registers.
// ============================================================================
`default_nettype none

module dopt_datapath #(
  parameter int unsigned TABLE_SLOTS = 256,
  parameter int unsigned MAX_AREA = 512
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [9:0]            cfg_wdata_i,
  input  wire logic [7:0]            data_byte_i,
  input  wire dopt_pkg::cmd_t        cmd_i,
  output dopt_pkg::sts_t             sts_o,
  output logic      [39:0]           result_o
);

  import dopt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_SLOTS);
  localparam logic [10:0] MaxAreaW = 11'(MAX_AREA);
  localparam logic [8:0] SlotLimit = 9'(TABLE_SLOTS - 1);
  localparam logic [AW-1:0] LastSlot = AW'(TABLE_SLOTS - 1);

  logic [AreaLenW-1:0] area_q;

  phase_e     phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0] skip_q, skip_d;
  logic [7:0] slot_cnt_q, slot_cnt_d;
  logic [7:0] count_q, count_d;
  logic       stopped_q, stopped_d;

  logic [TABLE_SLOTS-1:0] valid_q;

  logic            code_wr, len_wr;
  logic [AW-1:0]   slot_idx;
  logic [PosW-1:0] pos_inc;
  logic [10:0]     off_sum;
  logic [PosW-1:0] off_sat;
  logic [10:0]     limit;
  logic            at_limit;
  logic [7:0]      len_wdata;
  logic [PosW-1:0] off_wdata;

  logic [7:0]      query_q;
  logic [AW-1:0]   ptr_q;
  logic [AW-1:0]   rd_idx_q;
  logic            pending_q;
  logic            rd_vld_q;
  logic [7:0]      code_rd, len_rd;
  logic [PosW-1:0] off_rd;
  logic [7:0]      code_eff;
  logic            scan_found;

  logic            found_q;
  logic [7:0]      idx_q, len_q, count_out_q;
  logic [PosW-1:0] off_q;
  logic            done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q <= AreaLenReset;
    end else if (cfg_we_i) begin
      area_q <= cfg_wdata_i;
    end
  end

  assign slot_idx = slot_cnt_q[AW-1:0];
  assign pos_inc  = (pos_q == PosMax) ? pos_q : pos_q + 1'b1;
  assign off_sum  = {1'b0, pos_q} + 11'd2;
  assign off_sat  = (off_sum > {1'b0, PosMax}) ? PosMax : off_sum[PosW-1:0];
  assign limit    = ({1'b0, area_q} < MaxAreaW) ? {1'b0, area_q} : MaxAreaW;
  assign at_limit = ({1'b0, pos_q} >= limit) || ({1'b0, slot_cnt_q} >= SlotLimit);

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    skip_d     = skip_q;
    slot_cnt_d = slot_cnt_q;
    count_d    = count_q;
    stopped_d  = stopped_q;
    code_wr    = 1'b0;
    len_wr     = 1'b0;
    if (cmd_i.clear) begin
      phase_d    = PH_CODE;
      pos_d      = '0;
      skip_d     = '0;
      slot_cnt_d = '0;
      count_d    = '0;
      stopped_d  = 1'b0;
    end else if (cmd_i.byte_en && !stopped_q) begin
      unique case (phase_q)
        PH_CODE: begin
          if (at_limit) begin
            stopped_d = 1'b1;
          end else if (data_byte_i == PadCode) begin
            slot_cnt_d = slot_cnt_q + 8'd1;
            pos_d      = pos_inc;
          end else begin
            code_wr = 1'b1;
            if (data_byte_i == TermCode) begin
              stopped_d = 1'b1;
            end else begin
              pos_d   = pos_inc;
              phase_d = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          len_wr     = 1'b1;
          pos_d      = pos_inc;
          slot_cnt_d = slot_cnt_q + 8'd1;
          count_d    = count_q + 8'd1;
          skip_d     = data_byte_i;
          phase_d    = (data_byte_i == 8'd0) ? PH_CODE : PH_SKIP;
        end
        PH_SKIP: begin
          pos_d = pos_inc;
          if (skip_q != 8'd0) begin
            skip_d = skip_q - 8'd1;
          end
          if (skip_q <= 8'd1) begin
            phase_d = PH_CODE;
          end
        end
        default: begin
          phase_d = PH_CODE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CODE;
      pos_q      <= '0;
      skip_q     <= '0;
      slot_cnt_q <= '0;
      count_q    <= '0;
      stopped_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      skip_q     <= skip_d;
      slot_cnt_q <= slot_cnt_d;
      count_q    <= count_d;
      stopped_q  <= stopped_d;
    end
  end

  // a slot not written since the last start reads as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clear) begin
      valid_q <= '0;
    end else if (code_wr) begin
      valid_q[slot_idx] <= 1'b1;
    end
  end

  assign len_wdata = code_wr ? 8'd0 : data_byte_i;
  assign off_wdata = (data_byte_i == TermCode) ? '0 : off_sat;

  dopt_ram #(.Width(8), .Depth(TABLE_SLOTS)) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (code_wr),
    .waddr_i (slot_idx),
    .wdata_i (data_byte_i),
    .re_i    (cmd_i.scan_run),
    .raddr_i (ptr_q),
    .rdata_o (code_rd)
  );

  dopt_ram #(.Width(8), .Depth(TABLE_SLOTS)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (code_wr | len_wr),
    .waddr_i (slot_idx),
    .wdata_i (len_wdata),
    .re_i    (cmd_i.scan_run),
    .raddr_i (ptr_q),
    .rdata_o (len_rd)
  );

  dopt_ram #(.Width(PosW), .Depth(TABLE_SLOTS)) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (code_wr),
    .waddr_i (slot_idx),
    .wdata_i (off_wdata),
    .re_i    (cmd_i.scan_run),
    .raddr_i (ptr_q),
    .rdata_o (off_rd)
  );

  // scan: one slot address issued per cycle, its data checked on the registered read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      pending_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      ptr_q     <= '0;
      pending_q <= 1'b0;
    end else if (cmd_i.scan_run) begin
      ptr_q     <= ptr_q + 1'b1;
      pending_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      query_q <= data_byte_i;
    end
    if (cmd_i.scan_run) begin
      rd_idx_q <= ptr_q;
      rd_vld_q <= valid_q[ptr_q];
    end
  end

  assign code_eff   = rd_vld_q ? code_rd : 8'd0;
  assign scan_found = (code_eff == query_q);
  assign sts_o.scan_done = pending_q &&
                           (scan_found || (code_eff == TermCode) || (rd_idx_q == LastSlot));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_status) begin
      found_q     <= 1'b0;
      idx_q       <= '0;
      len_q       <= '0;
      off_q       <= '0;
      count_out_q <= count_d;
      done_q      <= stopped_d;
    end else if (cmd_i.load_lookup) begin
      found_q     <= scan_found;
      idx_q       <= 8'(rd_idx_q);
      len_q       <= (scan_found && rd_vld_q) ? len_rd : 8'd0;
      off_q       <= (scan_found && rd_vld_q) ? off_rd : '0;
      count_out_q <= count_q;
      done_q      <= stopped_q;
    end
  end

  assign result_o = {4'b0000, done_q, count_out_q, off_q, len_q, idx_q, found_q};

endmodule

`default_nettype wire

>>> hdl/dopt_ctrl.sv
// ============================================================================
// dopt_ctrl
// Transaction controller: input acceptance, lookup scan sequencing and the
// output valid register.
// ============================================================================
`default_nettype none

module dopt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_valid_i,
  input  wire logic [1:0]       opcode_i,
  output logic                  s_ready_o,
  output logic                  m_valid_o,
  input  wire logic             m_ready_i,
  output dopt_pkg::cmd_t        cmd_o,
  input  wire dopt_pkg::sts_t   sts_i
);

  import dopt_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  opcode_e     op;

  assign op = opcode_e'(opcode_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    s_ready_o   = 1'b0;
    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = !out_valid_q || m_ready_i;
        if (s_valid_i && s_ready_o) begin
          unique case (op)
            OP_START: begin
              cmd_o.clear       = 1'b1;
              cmd_o.load_status = 1'b1;
              out_valid_d       = 1'b1;
            end
            OP_BYTE: begin
              cmd_o.byte_en     = 1'b1;
              cmd_o.load_status = 1'b1;
              out_valid_d       = 1'b1;
            end
            OP_LOOKUP: begin
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SCAN;
            end
            OP_NOP: begin
              cmd_o.load_status = 1'b1;
              out_valid_d       = 1'b1;
            end
            default: begin
              cmd_o.load_status = 1'b1;
              out_valid_d       = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.load_lookup = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> hdl/dhcp_option_parser_table.sv
// ============================================================================
// dhcp_option_parser_table
// DHCP option area parser that records code, length and value offset of each
// option in a slot table and answers code lookups.
// ============================================================================
// Start, option byte and no-op transactions need no scan, so option bytes
// stream at one per cycle when the result side keeps up. A lookup holds the
// input while the scan reads one slot per cycle from the slot table memories,
// stopping at a hit, a terminator code or the last slot. The table needs no
// clearing pass after reset or start: per-slot valid bits make unwritten
// slots read as zero. Results wait in an output register; a new transaction
// is taken in the cycle that result is taken.
`default_nettype none

module dhcp_option_parser_table #(
  parameter int unsigned TABLE_SLOTS = 256,
  parameter int unsigned MAX_AREA = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [9:0]  cfg_wdata_i,     // area_length
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  wire logic [1:0]  s_axis_tuser,    // [1:0] opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] found, [8:1] slot_index, [16:9] option_length, [26:17] value_offset,
  // [34:27] option_count, [35] parse_done, [39:36] zero
  output logic      [39:0] m_axis_tdata
);

  import dopt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dopt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .opcode_i  (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  dopt_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .MAX_AREA    (MAX_AREA)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .data_byte_i (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> hdl/dopt_checker.sv
// ============================================================================
// dopt_checker
// Port-level checks for the DHCP option parser, bound to the top level.
// ============================================================================
`default_nettype none

module dopt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_accept_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result is blocked");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:36] == 4'b0000)
    else $error("tdata pad bits not zero");

  a_miss_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[26:9] == 18'd0)
    else $error("length or offset nonzero without a hit");

endmodule

bind dhcp_option_parser_table dopt_checker u_dopt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> bench/tb_dhcp_option_parser_table.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_dhcp_option_parser_table
// Self-checking bench for the DHCP option parser slot table. A directed table
// covers reset state, pads, zero-length records, terminator and ignored bytes;
// randomized option frames with lookups follow under several area lengths,
// including a run that fills the slot table. Every result is compared field
// by field against an in-bench model of parser and scan, or a typed reply.
// ============================================================================

module tb_dhcp_option_parser_table;
  import dopt_pkg::*;

  localparam int unsigned Slots = 256;
  localparam int unsigned AreaCap = 512;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned PhaseItems = 85;

  typedef struct packed {
    logic [3:0] spare;
    logic       parse_done;
    logic [7:0] option_count;
    logic [9:0] value_offset;
    logic [7:0] option_length;
    logic [7:0] slot_index;
    logic       found;
  } lookup_reply_t;

  typedef struct {
    opcode_e       op;
    logic [7:0]    data;
    bit            typed;
    lookup_reply_t reply;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [9:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic [1:0]  s_axis_tuser = '0;   // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // found, slot_index, length, offset, count, done

  dhcp_option_parser_table u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---- parser model state ----
  logic [7:0]    tbl_code [Slots];
  logic [7:0]    tbl_len [Slots];
  logic [9:0]    tbl_off [Slots];
  phase_e        phase;
  logic [9:0]    pos;
  logic [7:0]    skip_cnt;
  logic [7:0]    slot_cnt;
  logic [7:0]    opt_cnt;
  logic          halted;
  logic [9:0]    area_len_model = AreaLenReset;

  lookup_reply_t expected_replies [$];
  logic [7:0]    seen_codes [$];
  bit            typed_row = 1'b0;
  lookup_reply_t typed_reply_q = '0;
  int            err_count = 0;
  int            items_sent = 0;
  int            burst_left = 0;
  bit            gaps_on = 1'b1;
  int unsigned   idle_cycles = 0;

  function automatic void clear_table();
    for (int i = 0; i < Slots; i++) begin
      tbl_code[i] = '0;
      tbl_len[i] = '0;
      tbl_off[i] = '0;
    end
    phase = PH_CODE;
    pos = '0;
    skip_cnt = '0;
    slot_cnt = '0;
    opt_cnt = '0;
    halted = 1'b0;
  endfunction

  function automatic lookup_reply_t typed_reply(logic hit, logic [7:0] idx, logic [7:0] cnt,
                                                logic done);
    lookup_reply_t r;
    r = '0;
    r.found = hit;
    r.slot_index = idx;
    r.option_count = cnt;
    r.parse_done = done;
    return r;
  endfunction

  // Applies one transaction to the model and returns the reply it produces.
  function automatic lookup_reply_t option_table_step(opcode_e op, logic [7:0] b);
    lookup_reply_t r;
    int            n;
    logic [9:0]    lim;
    logic [7:0]    slot;
    logic [10:0]   off;
    r = '0;
    lim = (area_len_model > 10'(AreaCap)) ? 10'(AreaCap) : area_len_model;
    slot = slot_cnt;
    case (op)
      OP_START: clear_table();
      OP_BYTE: if (!halted) begin
        case (phase)
          PH_CODE: begin
            if (pos >= lim || slot_cnt >= 8'd255) begin
              halted = 1'b1;
            end else if (b == PadCode) begin
              slot_cnt = slot_cnt + 8'd1;
              if (pos != PosMax) pos = pos + 10'd1;
            end else begin
              tbl_code[slot] = b;
              if (b == TermCode) begin
                halted = 1'b1;
              end else begin
                off = {1'b0, pos} + 11'd2;
                tbl_off[slot] = (off > {1'b0, PosMax}) ? PosMax : off[9:0];
                if (pos != PosMax) pos = pos + 10'd1;
                phase = PH_LEN;
              end
            end
          end
          PH_LEN: begin
            tbl_len[slot] = b;
            if (pos != PosMax) pos = pos + 10'd1;
            slot_cnt = slot_cnt + 8'd1;
            opt_cnt = opt_cnt + 8'd1;
            if (b == 8'd0) begin
              phase = PH_CODE;
            end else begin
              skip_cnt = b;
              phase = PH_SKIP;
            end
          end
          default: begin
            if (pos != PosMax) pos = pos + 10'd1;
            if (skip_cnt != 8'd0) skip_cnt = skip_cnt - 8'd1;
            if (skip_cnt == 8'd0) phase = PH_CODE;
          end
        endcase
      end
      OP_LOOKUP: begin
        n = 0;
        while (n < Slots && tbl_code[n] != b && tbl_code[n] != TermCode) n++;
        if (n < Slots) begin
          r.slot_index = 8'(n);
          if (tbl_code[n] == b) begin
            r.found = 1'b1;
            r.option_length = tbl_len[n];
            r.value_offset = tbl_off[n];
          end
        end else begin
          r.slot_index = 8'(Slots - 1);
        end
      end
      default: ;
    endcase
    r.option_count = opt_cnt;
    r.parse_done = halted;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
    if (err_count < 40) $display("%0t: %s expected %0h got %0h", $realtime, what, want, got);
    err_count++;
  endtask

  // ---- prediction and checking, one place per edge ----
  always @(posedge clk_i) begin : monitor
    lookup_reply_t want;
    lookup_reply_t got;
    if (s_axis_tvalid && s_axis_tready) begin
      want = option_table_step(opcode_e'(s_axis_tuser), s_axis_tdata);
      expected_replies.push_back(typed_row ? typed_reply_q : want);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = lookup_reply_t'(m_axis_tdata);
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected result", '0, m_axis_tdata[15:0]);
      end else begin
        want = expected_replies.pop_front();
        if (got.found !== want.found) report_mismatch("found", want.found, got.found);
        if (got.slot_index !== want.slot_index)
          report_mismatch("slot_index", want.slot_index, got.slot_index);
        if (got.option_length !== want.option_length)
          report_mismatch("option_length", want.option_length, got.option_length);
        if (got.value_offset !== want.value_offset)
          report_mismatch("value_offset", want.value_offset, got.value_offset);
        if (got.option_count !== want.option_count)
          report_mismatch("option_count", want.option_count, got.option_count);
        if (got.parse_done !== want.parse_done)
          report_mismatch("parse_done", want.parse_done, got.parse_done);
        if (got.spare !== 4'd0) report_mismatch("spare bits", '0, got.spare);
      end
    end
  end

  // ---- receiver stall pattern ----
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 160);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ((rx_tick % 7) < 3);
      default: m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // ---- watchdog ----
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---- stimulus ----
  task automatic send_item(opcode_e op, logic [7:0] b, bit typed = 1'b0,
                           lookup_reply_t want = '0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= b;
    typed_row <= typed;
    typed_reply_q <= want;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    items_sent++;
  endtask

  task automatic hold_input();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_area(logic [9:0] val);
    hold_input();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    area_len_model = val;
  endtask

  function automatic logic [7:0] pick_code();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6 && seen_codes.size() != 0) return seen_codes[$urandom_range(0, seen_codes.size() - 1)];
    if (k == 6) return PadCode;
    if (k == 7) return TermCode;
    return 8'($urandom);
  endfunction

  // One option area: mostly well-formed records, some pads, noise and lookups.
  task automatic send_frame(int span);
    int         used;
    int         kind;
    int         len;
    logic [7:0] code;
    seen_codes.delete();
    send_item(OP_START, 8'($urandom));
    used = 0;
    while (used < span) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        send_item(OP_BYTE, PadCode);
        used++;
      end else if (kind < 12) begin
        send_item(OP_BYTE, TermCode);
        used = span;
      end else if (kind < 16) begin
        send_item(opcode_e'(2'($urandom_range(0, 3))), 8'($urandom));
        used++;
      end else if (kind < 22) begin
        send_item(OP_LOOKUP, pick_code());
      end else begin
        if (seen_codes.size() != 0 && $urandom_range(0, 7) == 0)
          code = seen_codes[$urandom_range(0, seen_codes.size() - 1)];
        else
          code = 8'($urandom_range(1, 254));
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(40, 255) : $urandom_range(0, 6);
        seen_codes.push_back(code);
        send_item(OP_BYTE, code);
        send_item(OP_BYTE, 8'(len));
        repeat (len) send_item(OP_BYTE, 8'($urandom));
        used += len + 2;
      end
    end
    repeat ($urandom_range(3, 7)) send_item(OP_LOOKUP, pick_code());
  endtask

  dir_row_t   directed_rows [25];
  logic [9:0] area_plan [9];
  int         mark;
  int         slots_used;

  initial begin
    clear_table();
    directed_rows = '{
      '{OP_LOOKUP, 8'h00, 1'b1, typed_reply(1'b1, 8'd0, 8'd0, 1'b0)},
      '{OP_LOOKUP, 8'hFF, 1'b1, typed_reply(1'b0, 8'd255, 8'd0, 1'b0)},
      '{OP_LOOKUP, 8'h42, 1'b1, typed_reply(1'b0, 8'd255, 8'd0, 1'b0)},
      '{OP_NOP,    8'hA5, 1'b1, typed_reply(1'b0, 8'd0, 8'd0, 1'b0)},
      '{OP_START,  8'h5A, 1'b1, typed_reply(1'b0, 8'd0, 8'd0, 1'b0)},
      '{OP_BYTE,   8'h00, 1'b0, '0},
      '{OP_BYTE,   8'h35, 1'b0, '0},
      '{OP_BYTE,   8'h01, 1'b0, '0},
      '{OP_BYTE,   8'hAA, 1'b0, '0},
      '{OP_BYTE,   8'h01, 1'b0, '0},
      '{OP_BYTE,   8'h00, 1'b0, '0},
      '{OP_BYTE,   8'h80, 1'b0, '0},
      '{OP_BYTE,   8'h02, 1'b0, '0},
      '{OP_BYTE,   8'hFF, 1'b0, '0},
      '{OP_BYTE,   8'h00, 1'b0, '0},
      '{OP_LOOKUP, 8'h35, 1'b0, '0},
      '{OP_LOOKUP, 8'h00, 1'b0, '0},
      '{OP_LOOKUP, 8'h80, 1'b0, '0},
      '{OP_LOOKUP, 8'h7E, 1'b0, '0},
      '{OP_BYTE,   8'hFF, 1'b0, '0},
      '{OP_BYTE,   8'h12, 1'b0, '0},
      '{OP_LOOKUP, 8'h12, 1'b0, '0},
      '{OP_LOOKUP, 8'hFF, 1'b0, '0},
      '{OP_START,  8'h00, 1'b1, typed_reply(1'b0, 8'd0, 8'd0, 1'b0)},
      '{OP_NOP,    8'hFF, 1'b1, typed_reply(1'b0, 8'd0, 8'd0, 1'b0)}
    };
    area_plan = '{10'd0, 10'd1, 10'd1023, 10'd512, 10'd3, 10'd0, 10'd308, 10'd0, 10'd1023};
    area_plan[5] = 10'($urandom_range(4, 40));
    area_plan[7] = 10'($urandom_range(1, 512));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
                directed_rows[i].reply);

    foreach (area_plan[i]) begin
      write_area(area_plan[i]);
      gaps_on = (i % 3 != 1);
      if (i == 2) begin
        // fill every usable slot with pads and empty records
        send_item(OP_START, 8'h00);
        slots_used = 0;
        while (slots_used < 255) begin
          if ($urandom_range(0, 3) == 0) begin
            send_item(OP_BYTE, 8'($urandom_range(1, 254)));
            send_item(OP_BYTE, 8'h00);
          end else begin
            send_item(OP_BYTE, PadCode);
          end
          slots_used++;
        end
        send_item(OP_BYTE, 8'($urandom_range(1, 254)));
        send_item(OP_BYTE, TermCode);
        send_item(OP_LOOKUP, PadCode);
        send_item(OP_LOOKUP, TermCode);
        send_item(OP_LOOKUP, 8'($urandom));
      end
      mark = items_sent;
      while (items_sent < mark + PhaseItems) send_frame($urandom_range(4, 48));
    end

    hold_input();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
